// File: sv/dyeq_pkg.sv
// ----------------------------------------------------------------------------
// dyeq_pkg
// Types, register map, reset values and sequencer step codes shared by the
// dynamic EQ gain computer modules.
// ----------------------------------------------------------------------------
package dyeq_pkg;

	// sample format is fixed by the transaction layout
	localparam int SAMPLE_BITS = 24;

	// configuration port geometry
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int RECIP_W     = 24;

	// 10*log10(2) in Q16
	localparam int DB_PER_LOG2_Q16 = 197283;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_DB    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REDUCTION_SLOPE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_COEFF    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_COEFF   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BAND_GAIN_DB    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_RECIPROCAL = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_MONO_MODE       = 3'd6;

	// register reset values
	localparam logic signed [14:0] THRESHOLD_DB_RST    = -15'sd5120;
	localparam logic [15:0]        REDUCTION_SLOPE_RST = 16'd32768;
	localparam logic [15:0]        ATTACK_COEFF_RST    = 16'd65000;
	localparam logic [15:0]        RELEASE_COEFF_RST   = 16'd65500;
	localparam logic signed [13:0] BAND_GAIN_DB_RST    = 14'sd0;
	localparam logic [23:0]        GAIN_RECIPROCAL_RST = 24'hFFFFFF;
	localparam logic               MONO_MODE_RST       = 1'b0;

	// sequencer steps, used as state codes and as datapath commands
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_IDLE = 5'd0;
	localparam logic [OP_W-1:0] OP_SQL  = 5'd1;
	localparam logic [OP_W-1:0] OP_SQR  = 5'd2;
	localparam logic [OP_W-1:0] OP_FOLL = 5'd3;
	localparam logic [OP_W-1:0] OP_FOLR = 5'd4;
	localparam logic [OP_W-1:0] OP_ENVR = 5'd5;
	localparam logic [OP_W-1:0] OP_MSB  = 5'd6;
	localparam logic [OP_W-1:0] OP_NORM = 5'd7;
	localparam logic [OP_W-1:0] OP_IDXM = 5'd8;
	localparam logic [OP_W-1:0] OP_TAB  = 5'd9;
	localparam logic [OP_W-1:0] OP_LVLM = 5'd10;
	localparam logic [OP_W-1:0] OP_LVL  = 5'd11;
	localparam logic [OP_W-1:0] OP_REDM = 5'd12;
	localparam logic [OP_W-1:0] OP_RED  = 5'd13;
	localparam logic [OP_W-1:0] OP_SCLM = 5'd14;
	localparam logic [OP_W-1:0] OP_SCL  = 5'd15;
	localparam logic [OP_W-1:0] OP_EFFM = 5'd16;
	localparam logic [OP_W-1:0] OP_DONE = 5'd17;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [13:0] effective_gain_db;
		logic [16:0]        dynamic_scale;
		logic [13:0]        reduction_db;
		logic signed [15:0] level_db;
	} out_item_t;

	typedef struct packed {
		logic signed [14:0] threshold_db;
		logic [15:0]        reduction_slope;
		logic [15:0]        attack_coeff;
		logic [15:0]        release_coeff;
		logic signed [13:0] band_gain_db;
		logic [RECIP_W-1:0] gain_reciprocal;
		logic               mono_mode;
	} cfg_t;

	// controller to datapath command
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            start;
		logic            load_out;
	} cmd_t;

endpackage

// File: sv/dynamic_eq_gain_computer.sv
// ----------------------------------------------------------------------------
// dynamic_eq_gain_computer
// Stereo envelope follower and compressor gain law for one dynamic EQ band.
// ----------------------------------------------------------------------------
// sequencing: each transaction walks the steps from SQL to DONE, waiting in
// DONE while the previous result still sits unread in the output register;
// no new transaction is taken until the last leaves DONE, as the steps share
// a single registered multiplier across all nine products
// reset: arst_n clears the envelopes, the sequencer and out_valid, and loads
// register defaults; no clearing pass, input is taken as soon as reset is released
module dynamic_eq_gain_computer #(
	parameter int ENVELOPE_BITS   = 32,
	parameter int LOG_TABLE_DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  dyeq_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output dyeq_pkg::out_item_t                 out_data,
	input  logic                                cfg_wr_en,
	input  logic [dyeq_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [dyeq_pkg::CFG_DATA_W-1:0]     cfg_data
);

	dyeq_pkg::cfg_t cfg_q;
	dyeq_pkg::cmd_t cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_db    <= dyeq_pkg::THRESHOLD_DB_RST;
			cfg_q.reduction_slope <= dyeq_pkg::REDUCTION_SLOPE_RST;
			cfg_q.attack_coeff    <= dyeq_pkg::ATTACK_COEFF_RST;
			cfg_q.release_coeff   <= dyeq_pkg::RELEASE_COEFF_RST;
			cfg_q.band_gain_db    <= dyeq_pkg::BAND_GAIN_DB_RST;
			cfg_q.gain_reciprocal <= dyeq_pkg::GAIN_RECIPROCAL_RST;
			cfg_q.mono_mode       <= dyeq_pkg::MONO_MODE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dyeq_pkg::REG_THRESHOLD_DB:    cfg_q.threshold_db    <= cfg_data[14:0];
				dyeq_pkg::REG_REDUCTION_SLOPE: cfg_q.reduction_slope <= cfg_data[15:0];
				dyeq_pkg::REG_ATTACK_COEFF:    cfg_q.attack_coeff    <= cfg_data[15:0];
				dyeq_pkg::REG_RELEASE_COEFF:   cfg_q.release_coeff   <= cfg_data[15:0];
				dyeq_pkg::REG_BAND_GAIN_DB:    cfg_q.band_gain_db    <= cfg_data[13:0];
				dyeq_pkg::REG_GAIN_RECIPROCAL: cfg_q.gain_reciprocal <= cfg_data[23:0];
				dyeq_pkg::REG_MONO_MODE:       cfg_q.mono_mode       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// step sequencer and handshakes
	dyeq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// arithmetic
	dyeq_dp #(
		.ENVELOPE_BITS   (ENVELOPE_BITS),
		.LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.in_data  (in_data),
		.out_data (out_data)
	);

	// one transaction in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a transaction is in flight");

	// scale never exceeds one
	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.dynamic_scale <= 17'h10000)
		else $error("dynamic scale above one");

	// no reduction means full scale
	a_no_red_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.reduction_db == 14'd0) |-> out_data.dynamic_scale == 17'h10000)
		else $error("scale below one without reduction");

	// detected level is never above full scale
	a_level_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.level_db[15] || (out_data.level_db == 16'sd0))
		else $error("positive detected level");

endmodule

// File: sv/dyeq_ctrl.sv
// ----------------------------------------------------------------------------
// dyeq_ctrl
// Sequencer for the gain computer: walks one transaction through the steps
// of the shared datapath and owns both channel handshakes.
// ----------------------------------------------------------------------------
module dyeq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output dyeq_pkg::cmd_t    cmd
);

	logic [dyeq_pkg::OP_W-1:0] state_q;
	logic [dyeq_pkg::OP_W-1:0] state_nxt;
	logic                      out_valid_q;
	logic                      slot_free;
	logic                      accept;
	logic                      load_out;

	// output register may be refilled when empty or being drained
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == dyeq_pkg::OP_IDLE);
	assign accept    = in_valid && in_ready;
	assign load_out  = (state_q == dyeq_pkg::OP_DONE) && slot_free;
	assign out_valid = out_valid_q;

	assign cmd.op       = state_q;
	assign cmd.start    = accept;
	assign cmd.load_out = load_out;

	// step sequence
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dyeq_pkg::OP_IDLE: begin
				if (accept) state_nxt = dyeq_pkg::OP_SQL;
			end
			dyeq_pkg::OP_SQL:  state_nxt = dyeq_pkg::OP_SQR;
			dyeq_pkg::OP_SQR:  state_nxt = dyeq_pkg::OP_FOLL;
			dyeq_pkg::OP_FOLL: state_nxt = dyeq_pkg::OP_FOLR;
			dyeq_pkg::OP_FOLR: state_nxt = dyeq_pkg::OP_ENVR;
			dyeq_pkg::OP_ENVR: state_nxt = dyeq_pkg::OP_MSB;
			dyeq_pkg::OP_MSB:  state_nxt = dyeq_pkg::OP_NORM;
			dyeq_pkg::OP_NORM: state_nxt = dyeq_pkg::OP_IDXM;
			dyeq_pkg::OP_IDXM: state_nxt = dyeq_pkg::OP_TAB;
			dyeq_pkg::OP_TAB:  state_nxt = dyeq_pkg::OP_LVLM;
			dyeq_pkg::OP_LVLM: state_nxt = dyeq_pkg::OP_LVL;
			dyeq_pkg::OP_LVL:  state_nxt = dyeq_pkg::OP_REDM;
			dyeq_pkg::OP_REDM: state_nxt = dyeq_pkg::OP_RED;
			dyeq_pkg::OP_RED:  state_nxt = dyeq_pkg::OP_SCLM;
			dyeq_pkg::OP_SCLM: state_nxt = dyeq_pkg::OP_SCL;
			dyeq_pkg::OP_SCL:  state_nxt = dyeq_pkg::OP_EFFM;
			dyeq_pkg::OP_EFFM: state_nxt = dyeq_pkg::OP_DONE;
			dyeq_pkg::OP_DONE: begin
				if (slot_free) state_nxt = dyeq_pkg::OP_IDLE;
			end
			default: state_nxt = dyeq_pkg::OP_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dyeq_pkg::OP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/dyeq_dp.sv
// ----------------------------------------------------------------------------
// dyeq_dp
// Datapath of the gain computer: envelope followers, log2 level detector and
// gain law, all built around one shared registered multiplier.
// ----------------------------------------------------------------------------
module dyeq_dp #(
	parameter int ENVELOPE_BITS   = 32,
	parameter int LOG_TABLE_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dyeq_pkg::cmd_t       cmd,
	input  dyeq_pkg::cfg_t       cfg,
	input  dyeq_pkg::in_item_t   in_data,
	output dyeq_pkg::out_item_t  out_data
);

	localparam int SB      = dyeq_pkg::SAMPLE_BITS;
	localparam int EB      = ENVELOPE_BITS;
	localparam int AW      = SB + 1;
	localparam int BW0     = (SB > dyeq_pkg::RECIP_W) ? SB + 1 : dyeq_pkg::RECIP_W + 1;
	localparam int BW      = (EB + 1 > BW0) ? EB + 1 : BW0;
	localparam int PW      = AW + BW;
	localparam int MW      = $clog2(EB);
	localparam int IW      = $clog2(LOG_TABLE_DEPTH);
	localparam int NLW     = $clog2(256 * EB + 1);
	localparam int SQ_FRAC = 2 * (SB - 1);
	localparam int SQW     = 2 * SB + EB;
	localparam int SHR     = (SQ_FRAC >= EB) ? SQ_FRAC - EB : 0;
	localparam int SHL     = (SQ_FRAC >= EB) ? 0 : EB - SQ_FRAC;

	// round(256*log2(1+idx/depth)) by repeated squaring in Q30
	function automatic logic [8:0] log_entry(input int idx);
		logic [63:0] x;
		logic [8:0]  v;
		logic [9:0]  r;
		x = ((64'(LOG_TABLE_DEPTH) + 64'(idx)) << 30) / LOG_TABLE_DEPTH;
		v = '0;
		for (int i = 0; i < 9; i++) begin
			x = (x * x) >> 30;
			v = {v[7:0], 1'b0};
			if (x >= (64'd2 << 30)) begin
				v[0] = 1'b1;
				x    = x >> 1;
			end
		end
		r = {1'b0, v} + 10'd1;
		return r[9:1];
	endfunction

	logic [8:0] log_rom [LOG_TABLE_DEPTH];

	for (genvar g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_rom
		assign log_rom[g] = log_entry(g);
	end

	logic [SB-1:0]          mag_l_q, mag_r_q;
	logic [EB-1:0]          sq_l_q, sq_r_q;
	logic [EB-1:0]          env_l_q, env_r_q;
	logic [EB-1:0]          e_q;
	logic [EB-2:0]          f_q;
	logic [MW-1:0]          msb_q;
	logic [8:0]             entry_q;
	logic signed [15:0]     level_q;
	logic                   pos_q;
	logic [13:0]            red_q;
	logic [16:0]            scale_q;
	logic signed [PW-1:0]   p_q;
	dyeq_pkg::out_item_t    out_q;

	logic signed [AW-1:0]   mul_a;
	logic signed [BW-1:0]   mul_b;
	logic [SB-1:0]          mag_l_c, mag_r_c;
	logic [SQW-1:0]         sq_wide;
	logic [EB-1:0]          sq_sat;
	logic [EB-1:0]          fol_sq, fol_env, env_base, env_upd;
	logic [15:0]            fol_coeff;
	logic signed [EB:0]     fol_diff;
	logic [EB-1:0]          env_sel, e_one;
	logic [MW-1:0]          msb_c;
	logic [MW-1:0]          shamt;
	logic [EB-1:0]          e_norm;
	logic [IW-1:0]          idx_c;
	logic [NLW-1:0]         neg_l;
	logic [PW-1:0]          rnd16, rnd8;
	logic [16:0]            lvl_mag;
	logic signed [16:0]     excess;
	logic [13:0]            red_sat;
	logic [16:0]            scale_c;
	logic [13:0]            gain_mag;
	logic [13:0]            eff_mag;
	logic signed [13:0]     eff_c;

	// sample magnitudes, full-scale negative maps to 2^(SB-1)
	assign mag_l_c = in_data.left_sample[SB-1]  ? SB'(-in_data.left_sample)  :
		SB'(in_data.left_sample);
	assign mag_r_c = in_data.right_sample[SB-1] ? SB'(-in_data.right_sample) :
		SB'(in_data.right_sample);

	// squared magnitude aligned to envelope fraction and saturated
	assign sq_wide = (SQW'(p_q[2*SB-1:0]) >> SHR) << SHL;
	assign sq_sat  = (|sq_wide[SQW-1:EB]) ? {EB{1'b1}} : sq_wide[EB-1:0];

	// one-pole follower: e' = sq + floor(a*(e-sq)/65536)
	assign fol_sq    = (cmd.op == dyeq_pkg::OP_FOLL) ? sq_l_q : sq_r_q;
	assign fol_env   = (cmd.op == dyeq_pkg::OP_FOLL) ? env_l_q : env_r_q;
	assign fol_coeff = (fol_sq > fol_env) ? cfg.attack_coeff : cfg.release_coeff;
	assign fol_diff  = $signed({1'b0, fol_env}) - $signed({1'b0, fol_sq});
	assign env_base  = (cmd.op == dyeq_pkg::OP_FOLR) ? sq_l_q : sq_r_q;
	assign env_upd   = env_base + p_q[16 +: EB];

	// envelope in use and its leading one
	assign env_sel = (!cfg.mono_mode && (env_r_q > env_l_q)) ? env_r_q : env_l_q;
	assign e_one   = (env_sel == '0) ? EB'(1) : env_sel;

	always_comb begin
		msb_c = '0;
		for (int b = 0; b < EB; b++) begin
			if (e_one[b]) msb_c = MW'(b);
		end
	end

	// normalize so the leading one sits at the top; the rest is the fraction
	assign shamt  = MW'(EB - 1) - msb_q;
	assign e_norm = e_q << shamt;

	// table index is below the depth since the fraction is below one
	assign idx_c = p_q[EB-1 +: IW];

	// minus log2 in Q8: 256*(EB - msb) - entry, never negative
	assign neg_l = NLW'(256 * EB) - NLW'({msb_q, 8'h00}) - NLW'(entry_q);

	// rounding helpers for the Q16 and Q8 products
	assign rnd16   = PW'(p_q) + PW'(32768);
	assign rnd8    = PW'(p_q) + PW'(128);
	assign lvl_mag = rnd16[16 +: 17];

	// excess over threshold
	assign excess = 17'(level_q) - 17'(cfg.threshold_db);

	// reduction, saturated to the field
	assign red_sat = (|rnd16[PW-1:30]) ? 14'h3FFF : rnd16[29:16];

	// scale = 1 - q, clamped at zero
	assign scale_c = (|rnd8[PW-1:24]) ? 17'd0 : 17'h10000 - {1'b0, rnd8[23:8]};

	// effective gain, magnitude rounded then sign restored
	assign gain_mag = cfg.band_gain_db[13] ? 14'(-cfg.band_gain_db) :
		14'(cfg.band_gain_db);
	assign eff_mag  = rnd16[16 +: 14];
	assign eff_c    = cfg.band_gain_db[13] ? $signed(14'd0 - eff_mag) : $signed(eff_mag);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			dyeq_pkg::OP_SQL: begin
				mul_a = AW'(mag_l_q);
				mul_b = BW'(mag_l_q);
			end
			dyeq_pkg::OP_SQR: begin
				mul_a = AW'(mag_r_q);
				mul_b = BW'(mag_r_q);
			end
			dyeq_pkg::OP_FOLL, dyeq_pkg::OP_FOLR: begin
				mul_a = AW'(fol_coeff);
				mul_b = BW'(fol_diff);
			end
			dyeq_pkg::OP_IDXM: begin
				mul_a = AW'(LOG_TABLE_DEPTH);
				mul_b = BW'(f_q);
			end
			dyeq_pkg::OP_LVLM: begin
				mul_a = AW'(neg_l);
				mul_b = BW'(dyeq_pkg::DB_PER_LOG2_Q16);
			end
			dyeq_pkg::OP_REDM: begin
				mul_a = AW'(excess);
				mul_b = BW'(cfg.reduction_slope);
			end
			dyeq_pkg::OP_SCLM: begin
				mul_a = AW'(red_q);
				mul_b = BW'(cfg.gain_reciprocal);
			end
			dyeq_pkg::OP_EFFM: begin
				mul_a = AW'(gain_mag);
				mul_b = BW'(scale_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// product register, held while the result waits for the output slot
	always_ff @(posedge clk) begin
		if (cmd.op != dyeq_pkg::OP_DONE) begin
			p_q <= mul_a * mul_b;
		end
	end

	// envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_l_q <= '0;
			env_r_q <= '0;
		end else begin
			if (cmd.op == dyeq_pkg::OP_FOLR) begin
				env_l_q <= env_upd;
			end
			if ((cmd.op == dyeq_pkg::OP_ENVR) && !cfg.mono_mode) begin
				env_r_q <= env_upd;
			end
		end
	end

	// per-step working registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mag_l_q <= mag_l_c;
			mag_r_q <= mag_r_c;
		end
		case (cmd.op)
			dyeq_pkg::OP_SQR:  sq_l_q  <= sq_sat;
			dyeq_pkg::OP_FOLL: sq_r_q  <= sq_sat;
			dyeq_pkg::OP_MSB: begin
				msb_q <= msb_c;
				e_q   <= e_one;
			end
			dyeq_pkg::OP_NORM: f_q     <= e_norm[EB-2:0];
			dyeq_pkg::OP_TAB:  entry_q <= log_rom[idx_c];
			dyeq_pkg::OP_LVL: begin
				level_q <= (lvl_mag > 17'd32768) ? -16'sd32768 : $signed(16'(17'd0 - lvl_mag));
			end
			dyeq_pkg::OP_REDM: pos_q   <= (excess > 17'sd0);
			dyeq_pkg::OP_RED:  red_q   <= pos_q ? red_sat : 14'd0;
			dyeq_pkg::OP_SCL:  scale_q <= scale_c;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.effective_gain_db <= eff_c;
			out_q.dynamic_scale     <= scale_q;
			out_q.reduction_db      <= red_q;
			out_q.level_db          <= level_q;
		end
	end

	assign out_data = out_q;

endmodule
